FILE: hdl/subtractive_random_generator_macros.svh
// assertion helpers for the block that checks itself
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SRG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SRG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/srg_pkg.sv
`default_nettype none

package srg_pkg;

  // table geometry
  localparam int unsigned TBL_DEPTH = 55;
  localparam int unsigned WORD_W    = 31;
  localparam int unsigned IDX_W     = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // request codes
  localparam logic [1:0] CMD_SEED    = 2'd0;
  localparam logic [1:0] CMD_UNIFORM = 2'd1;
  localparam logic [1:0] CMD_GAUSS   = 2'd2;

  // seeding and scrambling constants
  localparam logic [31:0] SEED_BASE = 32'd161803398;
  localparam logic [16:0] SCR_MUL   = 17'd84589;
  localparam word_t       SCR_ADD   = 31'd45989;

  // positions run 1..55
  localparam idx_t POS_FIRST   = 6'd1;
  localparam idx_t POS_LAST    = 6'd55;
  localparam idx_t POS_WRAP    = 6'd56;
  localparam idx_t FILL_STRIDE = 6'd21;
  localparam idx_t LAST_STEP   = 6'd54;
  // warm-up partner: i+31 up to position 24, i-24 beyond
  localparam idx_t WARM_SPLIT  = 6'd24;
  localparam idx_t WARM_FWD    = 6'd31;
  localparam idx_t WARM_BACK   = 6'd24;
  localparam logic [1:0] WARM_LAST_PASS = 2'd3;
  localparam idx_t LEAD_SEED   = 6'd0;
  localparam idx_t TRAIL_SEED  = 6'd31;
  localparam logic [3:0] GAUSS_LAST = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_FILL,
    ST_WARM_RD,
    ST_WARM_WR,
    ST_DRAW_RD,
    ST_DRAW_CALC,
    ST_SCR
  } state_t;

  // table access for one cycle
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } tbl_req_t;

  typedef struct packed {
    logic signed [31:0] draw_value;
    logic               is_gauss;
  } result_t;

  // next circular position, 56 and 0 wrap to 1
  function automatic idx_t step_index(idx_t v);
    idx_t n;
    n = v + POS_FIRST;
    return (n >= POS_WRAP || n == '0) ? POS_FIRST : n;
  endfunction

  // position to memory slot
  function automatic idx_t slot(idx_t pos);
    return (pos == '0) ? '0 : pos - POS_FIRST;
  endfunction

  // (d * 84589 + 45989) mod 2^31
  function automatic word_t scramble(word_t d);
    logic [47:0] prod;
    prod = 48'(d) * 48'(SCR_MUL);
    return WORD_W'(prod + 48'(SCR_ADD));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/srg_if.sv
`default_nettype none

// request channel
interface srg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] seed_value;

  modport source (output valid, cmd, seed_value, input ready);
  modport sink (input valid, cmd, seed_value, output ready);
endinterface

// result channel
interface srg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] draw_value;
  logic               is_gauss;

  modport source (output valid, draw_value, is_gauss, input ready);
  modport sink (input valid, draw_value, is_gauss, output ready);
endinterface

`default_nettype wire

FILE: hdl/srg_table.sv
`default_nettype none

module srg_table (
  input  logic             clk,
  input  logic             rst_n,
  input  srg_pkg::tbl_req_t tbl_req,
  output srg_pkg::word_t   rd_a,
  output srg_pkg::word_t   rd_b
);
  import srg_pkg::*;

  word_t                mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid_r;
  word_t                rd_a_r;
  word_t                rd_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (tbl_req.we) begin
      mem[tbl_req.waddr] <= tbl_req.wdata;
    end
    rd_a_r  <= mem[tbl_req.raddr_a];
    rd_b_r  <= mem[tbl_req.raddr_b];
    vld_a_r <= valid_r[tbl_req.raddr_a];
    vld_b_r <= valid_r[tbl_req.raddr_b];
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (tbl_req.we) begin
      valid_r[tbl_req.waddr] <= 1'b1;
    end
  end

  // never written entries read as zero
  assign rd_a = vld_a_r ? rd_a_r : '0;
  assign rd_b = vld_b_r ? rd_b_r : '0;

endmodule

`default_nettype wire

FILE: hdl/srg_seq.sv
`default_nettype none

module srg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_seed,
  output srg_pkg::tbl_req_t  tbl_req,
  input  srg_pkg::word_t     rd_a,
  input  srg_pkg::word_t     rd_b,
  output logic               res_valid,
  output srg_pkg::result_t   res,
  input  logic               res_ready
);
  import srg_pkg::*;

  state_t      state_r, state_nxt;
  idx_t        lead_r, lead_nxt;
  idx_t        trail_r, trail_nxt;
  idx_t        cnt_r, cnt_nxt;
  logic [1:0]  pass_r, pass_nxt;
  logic [3:0]  gcnt_r, gcnt_nxt;
  idx_t        pos_r, pos_nxt;
  word_t       mj_r, mj_nxt;
  word_t       mk_r, mk_nxt;
  word_t       mul_op_r, mul_op_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        gauss_r, gauss_nxt;

  word_t       diff;
  logic [31:0] ext;
  word_t       scr;
  idx_t        ln;
  idx_t        tn;
  logic [31:0] seed_u;
  logic [31:0] mag;
  logic [6:0]  pos_sum;
  idx_t        pos_step;
  idx_t        other;

  // datapath helpers
  assign diff     = rd_a - rd_b;
  assign ext      = {{8{diff[23]}}, diff[23:0]};
  assign scr      = scramble(mul_op_r);
  assign ln       = step_index(lead_r);
  assign tn       = step_index(trail_r);
  assign seed_u   = in_seed;
  assign mag      = seed_u[31] ? (32'd0 - seed_u) : seed_u;
  assign pos_sum  = {1'b0, pos_r} + {1'b0, FILL_STRIDE};
  assign pos_step = (pos_sum >= 7'(TBL_DEPTH)) ? 6'(pos_sum - 7'(TBL_DEPTH)) : pos_sum[5:0];
  assign other    = (cnt_r <= WARM_SPLIT) ? cnt_r + WARM_FWD : cnt_r - WARM_BACK;

  // result payload
  assign res.draw_value = gauss_r ? sum_r : {1'b0, scr};
  assign res.is_gauss   = gauss_r;

  // next state and table requests
  always_comb begin
    state_nxt  = state_r;
    lead_nxt   = lead_r;
    trail_nxt  = trail_r;
    cnt_nxt    = cnt_r;
    pass_nxt   = pass_r;
    gcnt_nxt   = gcnt_r;
    pos_nxt    = pos_r;
    mj_nxt     = mj_r;
    mk_nxt     = mk_r;
    mul_op_nxt = mul_op_r;
    sum_nxt    = sum_r;
    gauss_nxt  = gauss_r;
    tbl_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            CMD_SEED: begin
              mj_nxt    = WORD_W'(SEED_BASE - mag);
              state_nxt = ST_SEED;
            end
            CMD_UNIFORM: begin
              gauss_nxt = 1'b0;
              state_nxt = ST_DRAW_RD;
            end
            CMD_GAUSS: begin
              gauss_nxt = 1'b1;
              sum_nxt   = '0;
              gcnt_nxt  = '0;
              state_nxt = ST_DRAW_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // top position takes the seed word
      ST_SEED: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = slot(POS_LAST);
        tbl_req.wdata = mj_r;
        mk_nxt        = 31'd1;
        pos_nxt       = FILL_STRIDE;
        cnt_nxt       = POS_FIRST;
        state_nxt     = ST_FILL;
      end

      // interleaved fill, stride 21
      ST_FILL: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = slot(pos_r);
        tbl_req.wdata = mk_r;
        mk_nxt        = mj_r - mk_r;
        mj_nxt        = mk_r;
        pos_nxt       = pos_step;
        cnt_nxt       = cnt_r + POS_FIRST;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = POS_FIRST;
          pass_nxt  = '0;
          state_nxt = ST_WARM_RD;
        end
      end

      ST_WARM_RD: begin
        tbl_req.raddr_a = slot(cnt_r);
        tbl_req.raddr_b = slot(other);
        state_nxt       = ST_WARM_WR;
      end

      // warm-up write back, four passes over 1..54
      ST_WARM_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = slot(cnt_r);
        tbl_req.wdata = diff;
        state_nxt     = ST_WARM_RD;
        cnt_nxt       = cnt_r + POS_FIRST;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt = POS_FIRST;
          if (pass_r == WARM_LAST_PASS) begin
            lead_nxt  = LEAD_SEED;
            trail_nxt = TRAIL_SEED;
            state_nxt = ST_IDLE;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end
      end

      // advance both indices and fetch their words
      ST_DRAW_RD: begin
        lead_nxt        = ln;
        trail_nxt       = tn;
        tbl_req.raddr_a = slot(ln);
        tbl_req.raddr_b = slot(tn);
        state_nxt       = ST_DRAW_CALC;
      end

      ST_DRAW_CALC: begin
        if (gauss_r) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = slot(lead_r);
          tbl_req.wdata = diff;
          sum_nxt       = sum_r + ext;
          mul_op_nxt    = ext[WORD_W-1:0];
          gcnt_nxt      = gcnt_r + 4'd1;
          state_nxt     = (gcnt_r == GAUSS_LAST) ? ST_SCR : ST_DRAW_RD;
        end else begin
          mul_op_nxt = diff;
          state_nxt  = ST_SCR;
        end
      end

      // scrambled word back to the lead position, result out
      ST_SCR: begin
        if (res_ready) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = slot(lead_r);
          tbl_req.wdata = scr;
          res_valid     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lead_r  <= '0;
      trail_r <= '0;
      cnt_r   <= '0;
      pass_r  <= '0;
      gcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lead_r  <= lead_nxt;
      trail_r <= trail_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
      gcnt_r  <= gcnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    mj_r     <= mj_nxt;
    mk_r     <= mk_nxt;
    mul_op_r <= mul_op_nxt;
    sum_r    <= sum_nxt;
    gauss_r  <= gauss_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/subtractive_random_generator.sv
// uniform request: table read, difference and scramble states; requests are taken only while idle
// gauss request: twelve read/write table steps plus one scramble write
// reseed request: 55 fill writes and 4 x 54 warm-up steps, each a table read then a write
// rate set by the single table write port and the registered read before each write
// the final write of a draw waits while the output register is full
// reset clears indices, control and the table's written flags; the table reads as zero
`default_nettype none
`include "subtractive_random_generator_macros.svh"

module subtractive_random_generator (
  input  logic     clk,
  input  logic     rst_n,
  srg_in_if.sink   in_ch,
  srg_out_if.source out_ch
);
  import srg_pkg::*;

  tbl_req_t tbl_req;
  word_t    rd_a;
  word_t    rd_b;
  logic     res_valid;
  result_t  res;
  logic     res_ready;
  logic     out_valid_r;
  result_t  out_res_r;

  // state table
  srg_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .tbl_req (tbl_req),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  // command sequencer
  srg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_seed   (in_ch.seed_value),
    .tbl_req   (tbl_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.draw_value = out_res_r.draw_value;
  assign out_ch.is_gauss   = out_res_r.is_gauss;

  // checks
  `SRG_ASSERT_IMP(a_no_overwrite, res_valid, res_ready, "result overwrote a pending output")
  `SRG_ASSERT_IMP(a_result_when_busy, res_valid, !in_ch.ready, "result while request port idle")
  `SRG_ASSERT_NXT(a_busy_after_request, in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_SEED || in_ch.cmd == CMD_UNIFORM || in_ch.cmd == CMD_GAUSS), !in_ch.ready, "request did not start work")
  `SRG_ASSERT_NXT(a_result_loaded, res_valid, out_ch.valid && (out_ch.is_gauss == $past(res.is_gauss)), "result not loaded into output")

endmodule

`default_nettype wire

FILE: tb/sv/subtractive_random_generator_test.sv
`default_nettype none

module subtractive_random_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srg_pkg::*;

  // the one request code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 530;
  localparam int unsigned SETTLE_CYCLES   = 600;

  // expected draws from a shadow copy of the lagged table
  class draw_scoreboard;
    localparam logic [31:0] MIX_MUL   = 32'd84589;
    localparam logic [31:0] MIX_ADD   = 32'd45989;
    localparam logic [31:0] SEED_ROOT = 32'd161803398;

    word_t   words[55];
    idx_t    lead;
    idx_t    trail;
    result_t pending_draws[$];
    int      failures;

    function new();
      foreach (words[k]) words[k] = '0;
      lead     = '0;
      trail    = '0;
      failures = 0;
    endfunction

    // position 1..55 to array slot, position 0 lands on slot 0
    function int unsigned slot_of(idx_t pos);
      return (pos == '0) ? 0 : pos - 1;
    endfunction

    // circular step, 56 and the 6-bit wrap both go back to 1
    function idx_t next_pos(idx_t v);
      idx_t n;
      n = v + 6'd1;
      return (n >= 6'd56 || n == '0) ? 6'd1 : n;
    endfunction

    // (d * 84589 + 45989) mod 2^31
    function word_t mix_word(logic [31:0] d);
      logic [31:0] p;
      p = d * MIX_MUL + MIX_ADD;
      return p[30:0];
    endfunction

    // move both indices and take the plain difference
    function word_t next_difference();
      lead  = next_pos(lead);
      trail = next_pos(trail);
      return words[slot_of(lead)] - words[slot_of(trail)];
    endfunction

    // interleaved fill from the seed, then four warm-up passes
    function void reseed_words(logic [31:0] seed);
      logic [31:0] mag;
      logic [31:0] base;
      word_t       mj;
      word_t       mk;
      word_t       held;
      int unsigned pos;
      int unsigned partner;
      mag  = seed[31] ? (32'd0 - seed) : seed;
      base = SEED_ROOT - mag;
      mj   = base[30:0];
      mk   = 31'd1;
      words[54] = mj;
      for (int i = 1; i <= 54; i++) begin
        pos = (21 * i) % 55;
        words[pos - 1] = mk;
        held = mk;
        mk   = mj - mk;
        mj   = held;
      end
      for (int pass = 0; pass < 4; pass++) begin
        for (int i = 1; i < 55; i++) begin
          partner = 1 + (i + 30) % 55;
          words[i - 1] = words[i - 1] - words[partner - 1];
        end
      end
      lead  = 6'd0;
      trail = 6'd31;
    endfunction

    // accepted request: update the shadow state, queue the draw it gives
    function void note_request(logic [1:0] cmd, logic [31:0] seed);
      result_t     r;
      word_t       d;
      logic [31:0] ext;
      logic [31:0] sum;
      case (cmd)
        CMD_SEED: begin
          reseed_words(seed);
        end
        CMD_UNIFORM: begin
          d = mix_word({1'b0, next_difference()});
          words[slot_of(lead)] = d;
          r.draw_value = {1'b0, d};
          r.is_gauss   = 1'b0;
          pending_draws.push_back(r);
        end
        CMD_GAUSS: begin
          sum = '0;
          ext = '0;
          for (int k = 0; k < 12; k++) begin
            d = next_difference();
            words[slot_of(lead)] = d;
            ext = {{8{d[23]}}, d[23:0]};
            sum = sum + ext;
          end
          words[slot_of(lead)] = mix_word(ext);
          r.draw_value = sum;
          r.is_gauss   = 1'b1;
          pending_draws.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    // accepted draw against the oldest expected one
    function void check_result(logic signed [31:0] value, logic gauss);
      result_t exp_r;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected draw, expected none, actual value %0d gauss %0b",
                 $realtime, value, gauss);
        failures++;
        return;
      end
      exp_r = pending_draws.pop_front();
      if (value !== exp_r.draw_value) begin
        $display("%0t: draw_value mismatch, expected %0d actual %0d",
                 $realtime, exp_r.draw_value, value);
        failures++;
      end
      if (gauss !== exp_r.is_gauss) begin
        $display("%0t: is_gauss mismatch, expected %0b actual %0b",
                 $realtime, exp_r.is_gauss, gauss);
        failures++;
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  srg_in_if  req_ch ();
  srg_out_if draw_ch ();

  draw_scoreboard draws = new();

  subtractive_random_generator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (draw_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    draw_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // request monitor
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      draws.note_request(req_ch.cmd, req_ch.seed_value);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && draw_ch.valid && draw_ch.ready) begin
      draws.check_result(draw_ch.draw_value, draw_ch.is_gauss);
    end
  end

  // hard stop
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // seeds: full range, small magnitudes, around the seed base, extremes
  function automatic logic [31:0] pick_seed();
    logic [31:0] s;
    case ($urandom_range(3))
      0: s = $urandom;
      1: begin
        s = $urandom_range(1000);
        if ($urandom_range(1)) s = 32'd0 - s;
      end
      2: s = 32'd161803398 + $urandom_range(8) - 32'd4;
      default: s = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
    return s;
  endfunction

  // random mix, mostly draws with an occasional reseed
  task automatic run_random(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_request(CMD_SEED, pick_seed());
        done++;
      end else if (pick < 6) begin
        send_request(CMD_UNUSED, $urandom);
      end else if (pick < 62) begin
        send_request(CMD_UNIFORM, $urandom);
        done++;
      end else begin
        send_request(CMD_GAUSS, $urandom);
        done++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 79;
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_SEED;
    req_ch.seed_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // draws from the cleared table, before any seed
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_UNIFORM, 32'hffff_ffff);
    send_request(CMD_GAUSS, 32'h0);
    send_request(CMD_UNUSED, 32'h5a5a_a5a5);
    // seed extremes, each followed by draws
    send_request(CMD_SEED, 32'h0);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_GAUSS, 32'h0);
    send_request(CMD_SEED, 32'h8000_0000);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_SEED, 32'h7fff_ffff);
    send_request(CMD_GAUSS, 32'h0);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_SEED, 32'hffff_ffff);
    send_request(CMD_UNIFORM, 32'h0);
    // seed equal to the base, and one past it so the start word wraps
    send_request(CMD_SEED, 32'd161803398);
    send_request(CMD_GAUSS, 32'h0);
    send_request(CMD_SEED, 32'd161803399);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_UNUSED, 32'hffff_ffff);
    send_request(CMD_UNIFORM, 32'h0);
    send_request(CMD_GAUSS, 32'hffff_ffff);

    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 79;
    recv_idle_pct = 36;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    req_ch.valid <= 1'b0;

    // drain, then let a trailing reseed finish
    while (draws.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (draws.failures == 0 && draws.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
